// ===== src/cmad_pkg.sv =====
// cmad_pkg: shared types and constants for the cage-relative msd accumulator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package cmad_pkg;

	localparam int unsigned POS_W = 22;
	localparam int unsigned HALF_W = 21;
	localparam int unsigned DISP_W = 32;
	localparam int unsigned RAD_W = 44;
	localparam int unsigned SUM_W = 64;
	localparam int unsigned CNT_W = 32;

	// register indexes on the configuration port
	localparam logic [1:0] REG_BOX = 2'd0;
	localparam logic [1:0] REG_HALF = 2'd1;
	localparam logic [1:0] REG_RAD = 2'd2;

	typedef struct packed {
		logic signed [DISP_W-1:0] dy;
		logic signed [DISP_W-1:0] dx;
		logic [POS_W-1:0] y;
		logic [POS_W-1:0] x;
	} item_t;

	typedef struct packed {
		logic no_contrib;
		logic final_res;
		logic [SUM_W-1:0] msd;
		logic [CNT_W-1:0] count;
		logic [SUM_W-1:0] sum;
	} result_t;

endpackage
`default_nettype wire

// ===== src/cmad_div.sv =====
// cmad_div: unsigned 64 by 32 restoring divider, one quotient bit per cycle
// depends on cmad_pkg
`timescale 1ns / 1ps
`default_nettype none
module cmad_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [cmad_pkg::SUM_W-1:0] dividend,
	input wire logic [cmad_pkg::CNT_W-1:0] divisor,
	output logic done,
	output logic [cmad_pkg::SUM_W-1:0] quotient
);
	localparam int unsigned DW = cmad_pkg::SUM_W;
	localparam int unsigned VW = cmad_pkg::CNT_W;
	localparam int unsigned SW = $clog2(DW + 1);

	logic busy_q;
	logic done_q;
	logic [SW-1:0] step_q;
	logic [DW-1:0] a_q;
	logic [VW-1:0] b_q;
	logic [VW-1:0] r_q;
	logic [VW:0] r_try;
	logic [VW:0] r_sub;
	logic q_bit;

	always_comb begin
		r_try = {r_q, a_q[DW-1]};
		q_bit = (r_try >= {1'b0, b_q});
		r_sub = q_bit ? (r_try - {1'b0, b_q}) : r_try;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == SW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= dividend;
			b_q <= divisor;
			r_q <= '0;
		end else if (busy_q) begin
			a_q <= {a_q[DW-2:0], q_bit};
			r_q <= r_sub[VW-1:0];
		end
	end

	assign done = done_q;
	assign quotient = a_q;

endmodule
`default_nettype wire

// ===== src/cmad_front.sv =====
// cmad_front: takes input words, hands them to the particle store, queues frame closes
// depends on cmad_pkg
`timescale 1ns / 1ps
`default_nettype none
module cmad_front #(
	parameter int unsigned MAX_PARTICLES = 512
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire cmad_pkg::item_t in_item,
	input wire logic in_last_particle,
	input wire logic in_last_origin,
	input wire logic back_busy,
	output logic wr_en,
	output logic [$clog2(MAX_PARTICLES)-1:0] wr_addr,
	output cmad_pkg::item_t wr_item,
	output logic cmd_valid,
	output logic [$clog2(MAX_PARTICLES+1)-1:0] cmd_n,
	output logic cmd_last,
	input wire logic cmd_pop
);
	localparam int unsigned AW = $clog2(MAX_PARTICLES);
	localparam int unsigned CW = $clog2(MAX_PARTICLES + 1);

	logic [CW-1:0] cnt_q;
	logic [CW-1:0] cnt_next;
	logic take;
	logic room;
	logic [CW-1:0] qn_q [2];
	logic ql_q [2];
	logic wp_q, rp_q;
	logic [1:0] fill_q;
	logic push;

	assign room = (cnt_q < CW'(MAX_PARTICLES));
	// new frame data may only land once the back end has finished with the store
	assign in_ready = (fill_q == 2'd0) && !back_busy;
	assign take = in_valid && in_ready;
	assign wr_en = take && room;
	assign wr_addr = cnt_q[AW-1:0];
	assign wr_item = in_item;
	assign cnt_next = room ? (cnt_q + 1'b1) : cnt_q;
	assign push = take && in_last_particle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (take) cnt_q <= in_last_particle ? '0 : cnt_next;
			if (push) wp_q <= !wp_q;
			if (cmd_pop) rp_q <= !rp_q;
			fill_q <= fill_q + {1'b0, push} - {1'b0, cmd_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			qn_q[wp_q] <= cnt_next;
			ql_q[wp_q] <= in_last_origin;
		end
	end

	assign cmd_valid = (fill_q != 2'd0);
	assign cmd_n = qn_q[rp_q];
	assign cmd_last = ql_q[rp_q];

endmodule
`default_nettype wire

// ===== src/cmad_back.sv =====
// cmad_back: particle store, all-pairs neighbour pass, cage-relative sums, result register
// depends on cmad_pkg and cmad_div
`timescale 1ns / 1ps
`default_nettype none
module cmad_back #(
	parameter int unsigned MAX_PARTICLES = 512
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr_en,
	input wire logic [$clog2(MAX_PARTICLES)-1:0] wr_addr,
	input wire cmad_pkg::item_t wr_item,
	input wire logic cmd_valid,
	input wire logic [$clog2(MAX_PARTICLES+1)-1:0] cmd_n,
	input wire logic cmd_last,
	output logic cmd_pop,
	output logic busy,
	input wire logic [cmad_pkg::POS_W-1:0] box_length,
	input wire logic [cmad_pkg::HALF_W-1:0] half_box,
	input wire logic [cmad_pkg::RAD_W-1:0] cage_radius_sq,
	output logic out_valid,
	input wire logic out_ready,
	output cmad_pkg::result_t out_res
);
	localparam int unsigned AW = $clog2(MAX_PARTICLES);
	localparam int unsigned CW = $clog2(MAX_PARTICLES + 1);
	localparam int unsigned SXW = cmad_pkg::DISP_W + AW;
	localparam int unsigned DFW = cmad_pkg::POS_W + 2;
	localparam int unsigned SQW = 2 * DFW;
	localparam int unsigned DPW = cmad_pkg::DISP_W;
	localparam int unsigned SW = cmad_pkg::SUM_W;
	localparam int unsigned NW = cmad_pkg::CNT_W;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RDI = 4'd1;
	localparam logic [3:0] ST_LATI = 4'd2;
	localparam logic [3:0] ST_SCAN = 4'd3;
	localparam logic [3:0] ST_DRAIN = 4'd4;
	localparam logic [3:0] ST_DIVX = 4'd5;
	localparam logic [3:0] ST_DIVY = 4'd6;
	localparam logic [3:0] ST_RES = 4'd7;
	localparam logic [3:0] ST_SQ = 4'd8;
	localparam logic [3:0] ST_SUMC = 4'd9;
	localparam logic [3:0] ST_ACC = 4'd10;
	localparam logic [3:0] ST_NEXT = 4'd11;
	localparam logic [3:0] ST_FIN = 4'd12;
	localparam logic [3:0] ST_DIVM = 4'd13;
	localparam logic [3:0] ST_OUT = 4'd14;

	cmad_pkg::item_t mem [MAX_PARTICLES];
	cmad_pkg::item_t rd_q;
	logic [AW-1:0] raddr;

	logic [3:0] state_q;
	logic [CW-1:0] n_q, i_q, j_q;
	logic last_q;
	cmad_pkg::item_t own_q;

	logic v_s1, skip_s1, v_s2, v_s3;
	logic signed [DFW-1:0] fx_s2, fy_s2;
	logic signed [DPW-1:0] ddx_s2, ddy_s2, ddx_s3, ddy_s3;
	logic [SQW-1:0] sqx_s3, sqy_s3;

	logic signed [SXW-1:0] sx_q, sy_q;
	logic [AW-1:0] deg_q;
	logic signed [DPW:0] mx_q, my_q;
	logic [DPW-1:0] ax_q, ay_q;
	logic [SW-1:0] cx_q, cy_q, c_q;
	logic [SW-1:0] sum_q;
	logic [NW-1:0] count_q;
	logic out_valid_q;
	cmad_pkg::result_t res_q;

	logic div_start, div_done;
	logic [SW-1:0] div_a, div_q;
	logic [NW-1:0] div_b;

	cmad_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_a),
		.divisor(div_b), .done(div_done), .quotient(div_q)
	);

	// particle store, one read port
	assign raddr = (state_q == ST_SCAN) ? j_q[AW-1:0] : i_q[AW-1:0];
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_item;
		rd_q <= mem[raddr];
	end

	// minimum-image fold
	function automatic logic signed [DFW-1:0] fold(
		input logic [cmad_pkg::POS_W-1:0] a,
		input logic [cmad_pkg::POS_W-1:0] b,
		input logic [cmad_pkg::POS_W-1:0] len,
		input logic [cmad_pkg::HALF_W-1:0] hb
	);
		logic signed [DFW-1:0] d, h, l;
		begin
			d = $signed({2'b00, a}) - $signed({2'b00, b});
			h = $signed({3'b000, hb});
			l = $signed({2'b00, len});
			if (d > h) d = d - l;
			if (d < -h) d = d + l;
			fold = d;
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_SCAN);
			v_s2 <= v_s1 && !skip_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		skip_s1 <= (j_q == i_q);
		fx_s2 <= fold(own_q.x, rd_q.x, box_length, half_box);
		fy_s2 <= fold(own_q.y, rd_q.y, box_length, half_box);
		ddx_s2 <= rd_q.dx;
		ddy_s2 <= rd_q.dy;
		sqx_s3 <= SQW'(fx_s2 * fx_s2);
		sqy_s3 <= SQW'(fy_s2 * fy_s2);
		ddx_s3 <= ddx_s2;
		ddy_s3 <= ddy_s2;
	end

	// divider requests: neighbour means, then the final quotient
	always_comb begin
		div_start = 1'b0;
		div_a = '0;
		div_b = NW'(deg_q);
		case (state_q)
			ST_DRAIN: begin
				div_start = !v_s1 && !v_s2 && !v_s3 && (deg_q != '0);
				div_a = SW'(sx_q[SXW-1] ? -sx_q : sx_q);
			end
			ST_DIVX: begin
				div_start = div_done;
				div_a = SW'(sy_q[SXW-1] ? -sy_q : sy_q);
			end
			ST_FIN: begin
				div_start = last_q && (count_q != '0);
				div_a = sum_q;
				div_b = count_q;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	logic signed [DPW+1:0] rx, ry;
	logic [SW:0] c_wide, t_wide;
	logic load_out;
	logic out_free;
	logic [SW-1:0] msd_sel;

	always_comb begin
		rx = $signed({{2{own_q.dx[DPW-1]}}, own_q.dx}) - $signed({mx_q[DPW], mx_q});
		ry = $signed({{2{own_q.dy[DPW-1]}}, own_q.dy}) - $signed({my_q[DPW], my_q});
		c_wide = {1'b0, cx_q} + {1'b0, cy_q};
		t_wide = {1'b0, sum_q} + {1'b0, c_q};
		// the result register takes a new word once its current word is gone
		out_free = !out_valid_q || out_ready;
		load_out = out_free && (((state_q == ST_FIN) && !(last_q && (count_q != '0)))
			|| (state_q == ST_OUT));
		msd_sel = (state_q == ST_OUT) ? div_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sum_q <= '0;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) state_q <= (cmd_n == '0) ? ST_FIN : ST_RDI;
				end
				ST_RDI: state_q <= ST_LATI;
				ST_LATI: state_q <= ST_SCAN;
				ST_SCAN: begin
					if (j_q == n_q - 1'b1) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2 && !v_s3)
						state_q <= (deg_q == '0) ? ST_NEXT : ST_DIVX;
				end
				ST_DIVX: begin
					if (div_done) state_q <= ST_DIVY;
				end
				ST_DIVY: begin
					if (div_done) state_q <= ST_RES;
				end
				ST_RES: state_q <= ST_SQ;
				ST_SQ: state_q <= ST_SUMC;
				ST_SUMC: state_q <= ST_ACC;
				ST_ACC: begin
					sum_q <= t_wide[SW] ? '1 : t_wide[SW-1:0];
					if (count_q != '1) count_q <= count_q + 1'b1;
					state_q <= ST_NEXT;
				end
				ST_NEXT: state_q <= (i_q + 1'b1 == n_q) ? ST_FIN : ST_RDI;
				ST_FIN: begin
					if (last_q && (count_q != '0)) state_q <= ST_DIVM;
				end
				ST_DIVM: begin
					if (div_done) state_q <= ST_OUT;
				end
				// quotient held in the divider until the result register is free
				ST_OUT: state_q <= state_q;
				default: state_q <= ST_IDLE;
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
				state_q <= ST_IDLE;
				if (last_q) begin
					sum_q <= '0;
					count_q <= '0;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			n_q <= cmd_n;
			last_q <= cmd_last;
			i_q <= '0;
		end
		if (state_q == ST_NEXT) i_q <= i_q + 1'b1;
		if (state_q == ST_LATI) begin
			own_q <= rd_q;
			j_q <= '0;
			sx_q <= '0;
			sy_q <= '0;
			deg_q <= '0;
		end else begin
			if (state_q == ST_SCAN) j_q <= j_q + 1'b1;
			if (v_s3 && ({1'b0, sqx_s3} + {1'b0, sqy_s3} <= (SQW + 1)'(cage_radius_sq))) begin
				sx_q <= sx_q + SXW'(ddx_s3);
				sy_q <= sy_q + SXW'(ddy_s3);
				deg_q <= deg_q + 1'b1;
			end
		end
		// truncating signed means from magnitude quotients
		if (state_q == ST_DIVX && div_done)
			mx_q <= sx_q[SXW-1] ? -$signed({1'b0, div_q[DPW-1:0]}) : $signed({1'b0, div_q[DPW-1:0]});
		if (state_q == ST_DIVY && div_done)
			my_q <= sy_q[SXW-1] ? -$signed({1'b0, div_q[DPW-1:0]}) : $signed({1'b0, div_q[DPW-1:0]});
		if (state_q == ST_RES) begin
			ax_q <= DPW'(rx[DPW+1] ? -rx : rx);
			ay_q <= DPW'(ry[DPW+1] ? -ry : ry);
		end
		if (state_q == ST_SQ) begin
			cx_q <= SW'(ax_q) * SW'(ax_q);
			cy_q <= SW'(ay_q) * SW'(ay_q);
		end
		if (state_q == ST_SUMC) c_q <= c_wide[SW] ? '1 : c_wide[SW-1:0];
		if (load_out) begin
			res_q.sum <= sum_q;
			res_q.count <= count_q;
			res_q.msd <= msd_sel;
			res_q.final_res <= last_q;
			res_q.no_contrib <= (count_q == '0);
		end
	end

	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid;
	assign busy = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_res = res_q;

endmodule
`default_nettype wire

// ===== src/cage_relative_msd_accumulator.sv =====
// cage_relative_msd_accumulator: top level, configuration registers, front and back ends
// depends on cmad_pkg, cmad_front, cmad_back (cmad_div)
//
// channel   dir  handshake          fields
// s_axis    in   tvalid/tready      tdata: wrapped_x, wrapped_y, disp_x, disp_y; tlast; tuser
// m_axis    out  tvalid/tready      tdata: running_sum, running_count, msd_value; tlast; tuser
// apb       in   psel/penable       box_length @0, half_box @8, cage_radius_sq @16
//
// loading takes one particle word per cycle while the back end is idle and no frame close is queued
// a frame close with n stored particles scans all n words for each particle through the
// one read port; a particle with neighbours then takes two passes of the shared divider
// (x and y means); the final frame adds one more for the msd; input waits during a close
// a result word waiting in the output register stalls the next frame close at its end
// reset clears counters, totals and control; the store needs no clearing
`timescale 1ns / 1ps
`default_nettype none
module cage_relative_msd_accumulator #(
	parameter int unsigned MAX_PARTICLES = 512
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [111:0] s_tdata, // wrapped_x, wrapped_y, disp_x, disp_y, zero fill
	input wire logic s_tlast,
	input wire logic s_tuser, // last_origin
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [159:0] m_tdata, // running_sum, running_count, msd_value
	output logic m_tlast,
	output logic m_tuser, // no_contributors
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [4:0] paddr,
	input wire logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready
);
	localparam int unsigned AW = $clog2(MAX_PARTICLES);
	localparam int unsigned CW = $clog2(MAX_PARTICLES + 1);

	logic [cmad_pkg::POS_W-1:0] box_q;
	logic [cmad_pkg::HALF_W-1:0] half_q;
	logic [cmad_pkg::RAD_W-1:0] rad_q;
	logic [1:0] reg_idx;

	assign pready = 1'b1;
	assign reg_idx = paddr[4:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q <= 22'd2270234;
			half_q <= 21'd1135117;
			rad_q <= 44'd17179869184;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				cmad_pkg::REG_BOX: box_q <= pwdata[cmad_pkg::POS_W-1:0];
				cmad_pkg::REG_HALF: half_q <= pwdata[cmad_pkg::HALF_W-1:0];
				cmad_pkg::REG_RAD: rad_q <= pwdata[cmad_pkg::RAD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			cmad_pkg::REG_BOX: prdata = 64'(box_q);
			cmad_pkg::REG_HALF: prdata = 64'(half_q);
			cmad_pkg::REG_RAD: prdata = 64'(rad_q);
			default: prdata = '0;
		endcase
	end

	logic back_busy, wr_en, cmd_valid, cmd_last, cmd_pop;
	logic [AW-1:0] wr_addr;
	logic [CW-1:0] cmd_n;
	cmad_pkg::item_t wr_item;
	cmad_pkg::result_t res;

	cmad_front #(.MAX_PARTICLES(MAX_PARTICLES)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.in_item(cmad_pkg::item_t'(s_tdata[107:0])), .in_last_particle(s_tlast),
		.in_last_origin(s_tuser), .back_busy(back_busy), .wr_en(wr_en),
		.wr_addr(wr_addr), .wr_item(wr_item), .cmd_valid(cmd_valid),
		.cmd_n(cmd_n), .cmd_last(cmd_last), .cmd_pop(cmd_pop)
	);

	cmad_back #(.MAX_PARTICLES(MAX_PARTICLES)) u_back (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_addr(wr_addr),
		.wr_item(wr_item), .cmd_valid(cmd_valid), .cmd_n(cmd_n),
		.cmd_last(cmd_last), .cmd_pop(cmd_pop), .busy(back_busy),
		.box_length(box_q), .half_box(half_q), .cage_radius_sq(rad_q),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
	);

	assign m_tdata = {res.msd, res.count, res.sum};
	assign m_tlast = res.final_res;
	assign m_tuser = res.no_contrib;

	// a waiting result word holds still until taken
	a_hold_output: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result word changed while pending");
	a_msd_only_final: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> (m_tdata[159:96] == 64'd0))
		else $error("msd set on a non-final word");
	a_flag_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == (m_tdata[95:64] == 32'd0)))
		else $error("no_contributors disagrees with count");

endmodule
`default_nettype wire
